>>> src/ptc_pkg.sv
package ptc_pkg;

    localparam int unsigned CountWidth = 16;
    localparam int unsigned PrescaleWidth = 4;
    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth = 16;

    // Configuration register indexes
    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_TIMER_CONTROL   = 3'd0,
        CFG_PRESCALE_SELECT = 3'd1,
        CFG_CHANNELS        = 3'd2,
        CFG_CH1_MODE        = 3'd3,
        CFG_CH1_COMPARE     = 3'd4,
        CFG_CH2_MODE        = 3'd5,
        CFG_CH2_COMPARE     = 3'd6
    } t_cfg_idx;

    // Compare mode: bits 3:2 select compare, bits 1:0 the action
    localparam logic [1:0] MODE_COMPARE = 2'b10;

    typedef enum logic [1:0] {
        ACT_SET_PIN   = 2'd0,
        ACT_CLEAR_PIN = 2'd1,
        ACT_FLAG_ONLY = 2'd2,
        ACT_RESET_CNT = 2'd3
    } t_action;

    // Pin action codes on the result
    localparam logic [1:0] PIN_UNCHANGED = 2'd0;
    localparam logic [1:0] PIN_DRIVE_HI  = 2'd1;
    localparam logic [1:0] PIN_DRIVE_LO  = 2'd2;

    typedef struct packed {
        logic ext_clock_level;
        logic ch1_pin_is_output;
        logic ch2_pin_is_output;
        logic adc_enabled;
    } t_in;

    typedef struct packed {
        logic [CountWidth-1:0] count_value;
        logic                  overflow_event;
        logic                  ch1_match;
        logic                  ch2_match;
        logic [1:0]            ch1_pin_action;
        logic [1:0]            ch2_pin_action;
        logic                  adc_start;
    } t_out;

    typedef struct packed {
        logic [1:0]            timer_control;
        logic [1:0]            prescale_select;
        logic [1:0]            channels_present;
        logic [3:0]            ch1_mode;
        logic [CountWidth-1:0] ch1_compare;
        logic [3:0]            ch2_mode;
        logic [CountWidth-1:0] ch2_compare;
    } t_cfg;

    typedef struct packed {
        logic [PrescaleWidth-1:0] prescale_count;
        logic [CountWidth-1:0]    counter;
        logic                     last_clock_level;
    } t_state;

endpackage

>>> src/prescaled_timer_with_compare.sv
// Prescaled 16-bit timer with two compare channels, one tick per transfer.
// Path: a tick transferred sits in the input register, and its result is written
// to the result register and shows valid there once the result register can advance.
// Throughput: one tick per cycle; the result register and input register
// advance together, so only a stall on the result side slows the block.
// Reset (i_rst_n low, synchronous): counter, prescaler, pin history and all
// configuration registers clear to 0; both pipeline registers empty.
module prescaled_timer_with_compare
    import ptc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write port
    input  logic                     i_cfg_wr_en,
    input  logic [CfgIndexWidth-1:0] i_cfg_index,
    input  logic [CfgDataWidth-1:0]  i_cfg_wdata,
    // tick input channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_in                      i_in_data,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out                     o_out_data
);

    t_cfg   cfg;
    t_state r_state;
    t_state n_state;
    t_out   n_result;

    logic   r_in_vld;
    t_in    r_in;
    logic   r_out_vld;
    t_out   r_out;
    logic   advance;

    ptc_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Timer step for the tick held in the input register
    ptc_core u_core (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // The result register can take a new result when it is empty or its
    // current result transfers this cycle.
    assign advance    = !r_out_vld || !i_out_stall;
    // Stall the input only when a held tick cannot move on.
    assign o_in_stall = r_in_vld && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            // Input register: load on a transfer, otherwise empty once consumed
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            // Result register: commit the timer state with the result
            if (advance) begin
                r_out_vld <= r_in_vld;
                if (r_in_vld) begin
                    r_state <= n_state;
                end
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
        if (advance && r_in_vld) begin
            r_out <= n_result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

>>> src/ptc_regs.sv
module ptc_regs
    import ptc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [CfgIndexWidth-1:0] i_cfg_index,
    input  logic [CfgDataWidth-1:0]  i_cfg_wdata,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_TIMER_CONTROL:   r_cfg.timer_control    <= i_cfg_wdata[1:0];
                CFG_PRESCALE_SELECT: r_cfg.prescale_select  <= i_cfg_wdata[1:0];
                CFG_CHANNELS:        r_cfg.channels_present <= i_cfg_wdata[1:0];
                CFG_CH1_MODE:        r_cfg.ch1_mode         <= i_cfg_wdata[3:0];
                CFG_CH1_COMPARE:     r_cfg.ch1_compare      <= i_cfg_wdata[CountWidth-1:0];
                CFG_CH2_MODE:        r_cfg.ch2_mode         <= i_cfg_wdata[3:0];
                CFG_CH2_COMPARE:     r_cfg.ch2_compare      <= i_cfg_wdata[CountWidth-1:0];
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/ptc_core.sv
module ptc_core
    import ptc_pkg::*;
(
    input  t_cfg   i_cfg,
    input  t_state i_state,
    input  t_in    i_item,
    output t_state o_state,
    output t_out   o_result
);

    logic                     counted;
    logic [PrescaleWidth-1:0] pc_inc;
    logic [PrescaleWidth-1:0] divisor;
    logic                     step;
    logic [CountWidth-1:0]    cnt_step;
    logic [CountWidth-1:0]    cnt_ch1;
    logic [CountWidth-1:0]    cnt_ch2;
    logic                     hit1;
    logic                     hit2;
    t_action                  act1;
    t_action                  act2;

    always_comb begin
        counted = (i_cfg.timer_control == 2'b01) ||
                  (i_cfg.timer_control == 2'b11 && !i_state.last_clock_level &&
                   i_item.ext_clock_level);

        pc_inc   = i_state.prescale_count + PrescaleWidth'(1);
        divisor  = PrescaleWidth'(1) << i_cfg.prescale_select;
        step     = pc_inc >= divisor;
        cnt_step = step ? i_state.counter + CountWidth'(1) : i_state.counter;

        // Channel 1 sees the stepped counter
        act1    = t_action'(i_cfg.ch1_mode[1:0]);
        hit1    = i_cfg.channels_present[0] && i_cfg.ch1_mode[3:2] == MODE_COMPARE &&
                  cnt_step == i_cfg.ch1_compare;
        cnt_ch1 = (hit1 && act1 == ACT_RESET_CNT) ? '0 : cnt_step;

        // Channel 2 sees any reset made by channel 1
        act2    = t_action'(i_cfg.ch2_mode[1:0]);
        hit2    = i_cfg.channels_present[1] && i_cfg.ch2_mode[3:2] == MODE_COMPARE &&
                  cnt_ch1 == i_cfg.ch2_compare;
        cnt_ch2 = (hit2 && act2 == ACT_RESET_CNT) ? '0 : cnt_ch1;

        o_state.last_clock_level = i_item.ext_clock_level;
        o_result = '0;
        if (counted) begin
            o_state.prescale_count = step ? '0 : pc_inc;
            o_state.counter        = cnt_ch2;
            o_result.count_value    = cnt_ch2;
            o_result.overflow_event = step && cnt_step == '0;
            o_result.ch1_match      = hit1;
            o_result.ch2_match      = hit2;
            if (hit1 && i_item.ch1_pin_is_output) begin
                if (act1 == ACT_SET_PIN)   o_result.ch1_pin_action = PIN_DRIVE_HI;
                if (act1 == ACT_CLEAR_PIN) o_result.ch1_pin_action = PIN_DRIVE_LO;
            end
            if (hit2 && i_item.ch2_pin_is_output) begin
                if (act2 == ACT_SET_PIN)   o_result.ch2_pin_action = PIN_DRIVE_HI;
                if (act2 == ACT_CLEAR_PIN) o_result.ch2_pin_action = PIN_DRIVE_LO;
            end
            o_result.adc_start = hit2 && act2 == ACT_RESET_CNT && i_item.adc_enabled;
        end else begin
            o_state.prescale_count = i_state.prescale_count;
            o_state.counter        = i_state.counter;
            o_result.count_value   = i_state.counter;
        end
    end

endmodule

>>> src/ptc_checker.sv
module ptc_checker
    import ptc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A wrap always leaves the counter at zero
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.overflow_event |-> o_out_data.count_value == '0)
        else $error("overflow with nonzero count");

    // A conversion start comes only from a channel 2 match that reset the counter
    a_adc_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.adc_start |->
            o_out_data.ch2_match && o_out_data.count_value == '0 &&
            o_out_data.ch2_pin_action == PIN_UNCHANGED)
        else $error("adc start without channel 2 reset");

    // The channel 1 pin is driven only on a channel 1 match
    a_pin_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.ch1_pin_action != PIN_UNCHANGED) |->
            o_out_data.ch1_match &&
            (o_out_data.ch1_pin_action == PIN_DRIVE_HI ||
             o_out_data.ch1_pin_action == PIN_DRIVE_LO))
        else $error("channel 1 pin driven without match");

endmodule

bind prescaled_timer_with_compare ptc_checker u_ptc_checker (.*);
